/* design/mrbm_pkg.sv */
// Package for the largest all-ones rectangle block.
// Holds the size constants, field widths and the histogram stack entry type.
// No dependencies.
package mrbm_pkg;

  localparam int MaxSize   = 64;
  localparam int HgtW      = $clog2(MaxSize + 1);
  localparam int IdxW      = $clog2(MaxSize);
  localparam int CfgW      = 7;
  localparam int OutW      = 13;
  localparam int AreaMax   = 8191;
  localparam int AreaFullW = $clog2(MaxSize * MaxSize + 1);
  localparam int AreaW     = (AreaFullW > OutW) ? AreaFullW : OutW;

  localparam logic [CfgW-1:0] SizeReset = CfgW'(64);

  // One bar on the monotonic stack; left is the first column the bar spans.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [HgtW-1:0] hgt;
    logic [IdxW-1:0] left;
  } stk_entry_t;

  localparam int StkW = $bits(stk_entry_t);

endpackage

/* design/mrbm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/max_rectangle_in_binary_matrix_top.sv */
// Largest all-ones rectangle in a square binary matrix, cells in row-major order.
// A cell request reads, then writes the column height. The last cell of a row
// adds a histogram pass: each column push is a read, load and compare; each pop is a
// compare, plus a stack-top reload from the stack RAM when entries remain. The result
// follows the last row. Reset (asynchronous, active low) clears all heights at once
// via per-column valid bits; there is no clearing pass. Depends on mrbm_pkg and mrbm_ram.
module max_rectangle_in_binary_matrix_top import mrbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            matrix_size_we_i,
  input  logic [CfgW-1:0] matrix_size_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cell_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [OutW-1:0] max_area_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_POPW = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [CfgW-1:0]    size_q, size_d;
  logic [IdxW-1:0]    col_q, col_d;
  logic [HgtW-1:0]    row_q, row_d;
  logic [HgtW-1:0]    pos_q, pos_d;
  logic [HgtW-1:0]    sp_q, sp_d;
  logic               cell_q, cell_d;
  logic [HgtW-1:0]    hgt_q, hgt_d;
  stk_entry_t         top_q, top_d;
  logic [AreaW-1:0]   area_q, area_d;
  logic               area_v_q, area_v_d;
  logic [AreaW-1:0]   best_q, best_d;
  logic [MaxSize-1:0] hv_q, hv_d;

  logic [HgtW-1:0]    n_eff;
  logic               col_last;
  logic               pop;
  logic [HgtW-1:0]    hgt_cur;
  logic [2*HgtW-1:0]  mul_a, mul_b, prod;

  logic               h_we;
  logic [IdxW-1:0]    h_raddr;
  logic [HgtW-1:0]    h_wdata, h_rdata;
  logic               s_we;
  logic [IdxW-1:0]    s_waddr, s_raddr;
  logic [StkW-1:0]    s_rdata;

  // size 0 acts as 1, anything above the array acts as its full size
  always_comb begin
    if (size_q == '0) begin
      n_eff = HgtW'(1);
    end else if (int'(size_q) > MaxSize) begin
      n_eff = HgtW'(MaxSize);
    end else begin
      n_eff = HgtW'(size_q);
    end
  end

  assign col_last = (HgtW'(col_q) == n_eff - HgtW'(1));
  assign hgt_cur  = hv_q[col_q] ? h_rdata : '0;
  assign pop      = (sp_q != '0) && (top_q.hgt >= hgt_q);

  // area multiplier: bar height times span
  assign mul_a = {{HgtW{1'b0}}, top_q.hgt};
  assign mul_b = {{HgtW{1'b0}}, pos_q - HgtW'(top_q.left)};
  assign prod  = mul_a * mul_b;

  assign h_raddr = (state_q == S_IDLE) ? col_q : pos_q[IdxW-1:0];
  assign h_we    = (state_q == S_UPD);
  assign h_wdata = cell_q ? hgt_cur + HgtW'(1) : '0;

  // entries below the cached top live in the RAM at 0 .. sp-2
  assign s_waddr = IdxW'(sp_q - HgtW'(1));
  assign s_raddr = IdxW'(sp_q - HgtW'(2));

  mrbm_ram #(
    .Width (HgtW),
    .Depth (MaxSize)
  ) u_hgt_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (col_q),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  mrbm_ram #(
    .Width (StkW),
    .Depth (MaxSize)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (top_q),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_comb begin
    state_d  = state_q;
    size_d   = size_q;
    col_d    = col_q;
    row_d    = row_q;
    pos_d    = pos_q;
    sp_d     = sp_q;
    cell_d   = cell_q;
    hgt_d    = hgt_q;
    top_d    = top_q;
    area_d   = area_q;
    area_v_d = 1'b0;
    hv_d     = hv_q;
    s_we     = 1'b0;
    best_d   = (area_v_q && (area_q > best_q)) ? area_q : best_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cell_d  = cell_req_i;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        hv_d[col_q] = 1'b1;
        if (col_last) begin
          col_d   = '0;
          pos_d   = '0;
          sp_d    = '0;
          state_d = S_RD;
        end else begin
          col_d   = col_q + IdxW'(1);
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        // position n is the virtual zero bar that flushes the stack
        if ((pos_q < n_eff) && hv_q[pos_q[IdxW-1:0]]) begin
          hgt_d = h_rdata;
        end else begin
          hgt_d = '0;
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        if (pop) begin
          area_d   = AreaW'(prod);
          area_v_d = 1'b1;
          sp_d     = sp_q - HgtW'(1);
          state_d  = (sp_q > HgtW'(1)) ? S_POPW : S_CMP;
        end else if (pos_q < n_eff) begin
          s_we      = (sp_q != '0);
          top_d.idx = IdxW'(pos_q);
          top_d.hgt = hgt_q;
          top_d.left = (sp_q != '0) ? IdxW'(top_q.idx + IdxW'(1)) : '0;
          sp_d      = sp_q + HgtW'(1);
          pos_d     = pos_q + HgtW'(1);
          state_d   = S_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POPW: begin
        top_d   = stk_entry_t'(s_rdata);
        state_d = S_CMP;
      end
      S_FIN: begin
        row_d   = row_q + HgtW'(1);
        state_d = (row_q + HgtW'(1) == n_eff) ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          hv_d    = '0;
          col_d   = '0;
          row_d   = '0;
          best_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a size write restarts the matrix
    if (matrix_size_we_i) begin
      size_d   = matrix_size_i;
      hv_d     = '0;
      col_d    = '0;
      row_d    = '0;
      best_d   = '0;
      area_v_d = 1'b0;
      state_d  = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= SizeReset;
      col_q    <= '0;
      row_q    <= '0;
      pos_q    <= '0;
      sp_q     <= '0;
      area_v_q <= 1'b0;
      best_q   <= '0;
      hv_q     <= '0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pos_q    <= pos_d;
      sp_q     <= sp_d;
      area_v_q <= area_v_d;
      best_q   <= best_d;
      hv_q     <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    hgt_q  <= hgt_d;
    top_q  <= top_d;
    area_q <= area_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign max_area_o  = (best_q > AreaW'(AreaMax)) ? OutW'(AreaMax) : best_q[OutW-1:0];

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= HgtW'(MaxSize))
    else $error("stack pointer beyond array size");

  a_no_req_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("cell request taken while result pending");

  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((HgtW'(col_q) < n_eff) && (row_q < n_eff)))
    else $error("column or row count out of range while idle");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (pos_q <= n_eff))
    else $error("histogram position past the flush bar");

endmodule
